FILE: src/rrcl_pkg.sv
// Shared constants for the round-robin circular list block.
`timescale 1ns / 1ps

package rrcl_pkg;

  // Default sizing
  localparam int unsigned CAPACITY_DEF  = 16;
  localparam int unsigned ITEM_BITS_DEF = 32;

  // Stream payload widths
  localparam int unsigned CMD_W      = 2;
  localparam int unsigned IN_VAL_W   = 32;
  localparam int unsigned OUT_VAL_W  = 32;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned ENTRY_W    = 5;
  localparam int unsigned OUT_DATA_W = 40;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_ADD  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_NEXT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DEL  = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] STAT_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_MISS = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL = 2'd2;

endpackage

FILE: src/rrcl_ram.sv
// Generic single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps

module rrcl_ram #(
  parameter int unsigned WIDTH = rrcl_pkg::ITEM_BITS_DEF,
  parameter int unsigned DEPTH = rrcl_pkg::CAPACITY_DEF
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: src/round_robin_circular_list.sv
// Top level of the round-robin circular list: sequencer, ring memories and output register.
`timescale 1ns / 1ps

// Round-robin circular list of up to CAPACITY values. Each input word carries a command in
// tuser (add, next, delete) and a value in tdata; each word yields exactly one result word.
// The ring lives in two single-port-read memories (values and links) driven by one small
// sequencer, so one command is in flight at a time and s_axis_tready is low meanwhile.
// Add steps through ST_ADD0 to ST_ADD3 (an add into an empty list ends after ST_ADD2), next
// through ST_NXT0 to ST_NXT2, and delete through ST_DEL0, ST_DEL1, ST_WALK (the walk reads
// one link per cycle until a match or a full lap) and ST_FREE on a match; a command that finds
// the list full or empty, or an unused code, goes straight to ST_OUT. Loading the result word
// waits while the previous result word is still held by the receiver. The block is
// ready again in the cycle after the result is loaded; a waiting result word does not block
// the next command.
// Freed slots go on a free list threaded through the link memory, so no clearing pass is
// needed after reset.
module round_robin_circular_list #(
  parameter int unsigned CAPACITY  = rrcl_pkg::CAPACITY_DEF,
  parameter int unsigned ITEM_BITS = rrcl_pkg::ITEM_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // slave side
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [rrcl_pkg::IN_VAL_W-1:0]     s_axis_tdata,   // [31:0] item_value
  input  logic [rrcl_pkg::CMD_W-1:0]        s_axis_tuser,   // [1:0] command
  // master side
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [rrcl_pkg::OUT_DATA_W-1:0]   m_axis_tdata    // [31:0] out_value,
                                                            // [33:32] status,
                                                            // [38:34] entry_count,
                                                            // [39] is_empty, rest zero
);

  localparam int unsigned SLOT_W = $clog2(CAPACITY);
  localparam int unsigned CNT_W  = $clog2(CAPACITY + 1);
  localparam int unsigned ST_W   = 4;

  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  // sequencer states
  localparam logic [ST_W-1:0] ST_IDLE = 4'd0;
  localparam logic [ST_W-1:0] ST_ADD0 = 4'd1;
  localparam logic [ST_W-1:0] ST_ADD1 = 4'd2;
  localparam logic [ST_W-1:0] ST_ADD2 = 4'd3;
  localparam logic [ST_W-1:0] ST_ADD3 = 4'd4;
  localparam logic [ST_W-1:0] ST_NXT0 = 4'd5;
  localparam logic [ST_W-1:0] ST_NXT1 = 4'd6;
  localparam logic [ST_W-1:0] ST_NXT2 = 4'd7;
  localparam logic [ST_W-1:0] ST_DEL0 = 4'd8;
  localparam logic [ST_W-1:0] ST_DEL1 = 4'd9;
  localparam logic [ST_W-1:0] ST_WALK = 4'd10;
  localparam logic [ST_W-1:0] ST_FREE = 4'd11;
  localparam logic [ST_W-1:0] ST_OUT  = 4'd12;

  // control state
  logic [ST_W-1:0]   state_q, state_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [CNT_W-1:0]  fresh_q, fresh_d;      // slots ever handed out
  logic [SLOT_W-1:0] free_head_q, free_head_d;
  logic [SLOT_W-1:0] cursor_q, cursor_d;
  logic [CNT_W-1:0]  walk_q, walk_d;
  logic              m_valid_q, m_valid_d;

  // payload state
  logic [ITEM_BITS-1:0]            val_q, val_d;
  logic [ITEM_BITS-1:0]            vc_q, vc_d;
  logic [SLOT_W-1:0]               new_slot_q, new_slot_d;
  logic                            pop_q, pop_d;
  logic [SLOT_W-1:0]               prev_q, prev_d;
  logic [SLOT_W-1:0]               cur_q, cur_d;
  logic [rrcl_pkg::OUT_VAL_W-1:0]  res_val_q, res_val_d;
  logic [rrcl_pkg::STATUS_W-1:0]   res_st_q, res_st_d;
  logic [rrcl_pkg::OUT_DATA_W-1:0] m_data_q, m_data_d;

  // memory ports
  logic                 vr_we, lr_we;
  logic [SLOT_W-1:0]    vr_waddr, vr_raddr, lr_waddr, lr_raddr;
  logic [ITEM_BITS-1:0] vr_wdata, vr_rdata;
  logic [SLOT_W-1:0]    lr_wdata, lr_rdata;

  // width adapters
  logic [ITEM_BITS+rrcl_pkg::IN_VAL_W-1:0]  in_ext;
  logic [ITEM_BITS+rrcl_pkg::OUT_VAL_W-1:0] out_ext;
  logic [CNT_W+rrcl_pkg::ENTRY_W-1:0]       cnt_ext;
  logic                                     s_fire;

  assign in_ext  = {{ITEM_BITS{1'b0}}, s_axis_tdata};
  assign out_ext = {{rrcl_pkg::OUT_VAL_W{1'b0}}, vr_rdata};
  assign cnt_ext = {{rrcl_pkg::ENTRY_W{1'b0}}, count_q};

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  rrcl_ram #(
    .WIDTH (ITEM_BITS),
    .DEPTH (CAPACITY)
  ) u_value_ram (
    .clk_i   (clk_i),
    .we_i    (vr_we),
    .waddr_i (vr_waddr),
    .wdata_i (vr_wdata),
    .raddr_i (vr_raddr),
    .rdata_o (vr_rdata)
  );

  rrcl_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (CAPACITY)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (lr_we),
    .waddr_i (lr_waddr),
    .wdata_i (lr_wdata),
    .raddr_i (lr_raddr),
    .rdata_o (lr_rdata)
  );

  // sequencer
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    fresh_d     = fresh_q;
    free_head_d = free_head_q;
    cursor_d    = cursor_q;
    walk_d      = walk_q;
    m_valid_d   = m_valid_q;
    val_d       = val_q;
    vc_d        = vc_q;
    new_slot_d  = new_slot_q;
    pop_d       = pop_q;
    prev_d      = prev_q;
    cur_d       = cur_q;
    res_val_d   = res_val_q;
    res_st_d    = res_st_q;
    m_data_d    = m_data_q;

    vr_we    = 1'b0;
    vr_waddr = cursor_q;
    vr_wdata = val_q;
    vr_raddr = cursor_q;
    lr_we    = 1'b0;
    lr_waddr = cursor_q;
    lr_wdata = new_slot_q;
    lr_raddr = cursor_q;

    // result word drains independently
    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (s_fire) begin
          val_d     = in_ext[ITEM_BITS-1:0];
          res_val_d = '0;
          res_st_d  = rrcl_pkg::STAT_OK;
          unique case (s_axis_tuser)
            rrcl_pkg::CMD_ADD: begin
              if (count_q == CAP_CNT) begin
                res_st_d = rrcl_pkg::STAT_FULL;
                state_d  = ST_OUT;
              end else begin
                state_d = ST_ADD0;
              end
            end
            rrcl_pkg::CMD_NEXT: begin
              if (count_q == '0) begin
                res_st_d = rrcl_pkg::STAT_MISS;
                state_d  = ST_OUT;
              end else begin
                state_d = ST_NXT0;
              end
            end
            rrcl_pkg::CMD_DEL: begin
              if (count_q == '0) begin
                res_st_d = rrcl_pkg::STAT_MISS;
                state_d  = ST_OUT;
              end else begin
                state_d = ST_DEL0;
              end
            end
            default: begin
              state_d = ST_OUT;
            end
          endcase
        end
      end

      // pick a slot: reuse the free list head, else a never-used slot
      ST_ADD0: begin
        pop_d      = (fresh_q != count_q);
        new_slot_d = (fresh_q != count_q) ? free_head_q : fresh_q[SLOT_W-1:0];
        lr_raddr   = new_slot_d;
        vr_raddr   = cursor_q;
        state_d    = ST_ADD1;
      end

      // unlink the slot from the free list, park the new value
      ST_ADD1: begin
        if (pop_q) begin
          free_head_d = lr_rdata;
        end else begin
          fresh_d = fresh_q + 1'b1;
        end
        vc_d     = vr_rdata;
        lr_raddr = cursor_q;
        vr_we    = 1'b1;
        vr_waddr = (count_q == '0) ? new_slot_q : cursor_q;
        vr_wdata = val_q;
        state_d  = ST_ADD2;
      end

      // old cursor entry moves into the new slot
      ST_ADD2: begin
        lr_we    = 1'b1;
        lr_waddr = new_slot_q;
        if (count_q == '0) begin
          lr_wdata = new_slot_q;
          cursor_d = new_slot_q;
          count_d  = count_q + 1'b1;
          state_d  = ST_OUT;
        end else begin
          lr_wdata = lr_rdata;
          vr_we    = 1'b1;
          vr_waddr = new_slot_q;
          vr_wdata = vc_q;
          state_d  = ST_ADD3;
        end
      end

      ST_ADD3: begin
        lr_we    = 1'b1;
        lr_waddr = cursor_q;
        lr_wdata = new_slot_q;
        cursor_d = new_slot_q;
        count_d  = count_q + 1'b1;
        state_d  = ST_OUT;
      end

      // next: follow the cursor link, then fetch the value
      ST_NXT0: begin
        lr_raddr = cursor_q;
        state_d  = ST_NXT1;
      end

      ST_NXT1: begin
        vr_raddr = lr_rdata;
        cursor_d = lr_rdata;
        state_d  = ST_NXT2;
      end

      ST_NXT2: begin
        res_val_d = out_ext[rrcl_pkg::OUT_VAL_W-1:0];
        state_d   = ST_OUT;
      end

      // delete: start the walk at the entry after the cursor
      ST_DEL0: begin
        lr_raddr = cursor_q;
        prev_d   = cursor_q;
        walk_d   = '0;
        state_d  = ST_DEL1;
      end

      ST_DEL1: begin
        cur_d    = lr_rdata;
        vr_raddr = lr_rdata;
        lr_raddr = lr_rdata;
        state_d  = ST_WALK;
      end

      // one entry per cycle; the fetched link addresses the next read
      ST_WALK: begin
        if (vr_rdata == val_q) begin
          lr_we    = 1'b1;
          lr_waddr = prev_q;
          lr_wdata = lr_rdata;
          if (cursor_q == cur_q) begin
            cursor_d = prev_q;
          end
          state_d = ST_FREE;
        end else if (walk_q + 1'b1 == count_q) begin
          res_st_d = rrcl_pkg::STAT_MISS;
          state_d  = ST_OUT;
        end else begin
          prev_d   = cur_q;
          cur_d    = lr_rdata;
          vr_raddr = lr_rdata;
          lr_raddr = lr_rdata;
          walk_d   = walk_q + 1'b1;
        end
      end

      // push the freed slot onto the free list
      ST_FREE: begin
        lr_we       = 1'b1;
        lr_waddr    = cur_q;
        lr_wdata    = free_head_q;
        free_head_d = cur_q;
        count_d     = count_q - 1'b1;
        state_d     = ST_OUT;
      end

      // load the result word once the output register is free
      ST_OUT: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_data_d  = {(count_q == '0), cnt_ext[rrcl_pkg::ENTRY_W-1:0], res_st_q, res_val_q};
          state_d   = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      fresh_q     <= '0;
      free_head_q <= '0;
      cursor_q    <= '0;
      walk_q      <= '0;
      m_valid_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      fresh_q     <= fresh_d;
      free_head_q <= free_head_d;
      cursor_q    <= cursor_d;
      walk_q      <= walk_d;
      m_valid_q   <= m_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    val_q      <= val_d;
    vc_q       <= vc_d;
    new_slot_q <= new_slot_d;
    pop_q      <= pop_d;
    prev_q     <= prev_d;
    cur_q      <= cur_d;
    res_val_q  <= res_val_d;
    res_st_q   <= res_st_d;
    m_data_q   <= m_data_d;
  end

  // checks
  a_count_le_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CAP_CNT)
    else $error("entry count above capacity");

  a_fresh_covers_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= fresh_q)
    else $error("more entries than slots handed out");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire |=> !s_axis_tready)
    else $error("new word taken while a command is in flight");

  a_walk_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK) |-> (walk_q < count_q))
    else $error("delete walk ran past the ring");

endmodule

FILE: tb/tb_round_robin_circular_list.sv
// Self-checking testbench for the round-robin circular list: random stream traffic vs. a model.
`timescale 1ns / 1ps

module tb_round_robin_circular_list;

  localparam int unsigned CAP        = rrcl_pkg::CAPACITY_DEF;
  localparam int unsigned SLOT_W     = $clog2(CAP);
  localparam int          IDLE_LIMIT = 4000;
  localparam int          RAND_WORDS = 650;
  localparam int          POOL_N     = 10;

  // command code that the block ignores
  localparam logic [rrcl_pkg::CMD_W-1:0] CMD_NONE = 2'd3;

  // random traffic shapes
  localparam int MODE_ADD_ONLY = 0;
  localparam int MODE_FILL     = 1;
  localparam int MODE_DRAIN    = 2;
  localparam int MODE_MIX      = 3;

  typedef struct packed {
    logic [rrcl_pkg::CMD_W-1:0]    cmd;
    logic [rrcl_pkg::IN_VAL_W-1:0] value;
  } cmd_word_t;

  // same layout as m_axis_tdata, top field first
  typedef struct packed {
    logic                           is_empty;
    logic [rrcl_pkg::ENTRY_W-1:0]   entry_count;
    logic [rrcl_pkg::STATUS_W-1:0]  status;
    logic [rrcl_pkg::OUT_VAL_W-1:0] out_value;
  } list_result_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [rrcl_pkg::IN_VAL_W-1:0]   s_axis_tdata  = '0;
  logic [rrcl_pkg::CMD_W-1:0]      s_axis_tuser  = '0;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [rrcl_pkg::OUT_DATA_W-1:0] m_axis_tdata;

  round_robin_circular_list dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // stimulus and expectation stores
  cmd_word_t    cmd_words [$];
  list_result_t expected_results [$];

  int words_in    = 0;
  int words_out   = 0;
  int idle_cycles = 0;
  int error_count = 0;
  int in_gap      = 0;
  int rdy_gap     = 0;
  int hold_left   = 0;
  bit hold_done   = 1'b0;

  logic [rrcl_pkg::IN_VAL_W-1:0] val_pool [POOL_N];

  // predicted ring contents
  logic [rrcl_pkg::IN_VAL_W-1:0] ring_val  [CAP];
  logic [SLOT_W-1:0]             ring_link [CAP];
  bit                            slot_busy [CAP];
  logic [SLOT_W-1:0]             ring_cursor = '0;
  int                            ring_count  = 0;

  // Advance the predicted ring by one command and return the result word it yields.
  function automatic list_result_t predict_result(logic [rrcl_pkg::CMD_W-1:0] cmd,
                                                  logic [rrcl_pkg::IN_VAL_W-1:0] val);
    list_result_t r;
    int s;
    int i;
    bit done;
    logic [SLOT_W-1:0] prev;
    logic [SLOT_W-1:0] cur;
    r = '0;
    r.status = rrcl_pkg::STAT_OK;
    case (cmd)
      rrcl_pkg::CMD_ADD: begin
        if (ring_count >= CAP) begin
          r.status = rrcl_pkg::STAT_FULL;
        end else begin
          s = 0;
          while (slot_busy[s]) s++;
          slot_busy[s] = 1'b1;
          if (ring_count == 0) begin
            ring_val[s]  = val;
            ring_link[s] = SLOT_W'(s);
          end else begin
            // old cursor entry moves to the fresh slot, new value takes its place
            ring_val[s]            = ring_val[ring_cursor];
            ring_val[ring_cursor]  = val;
            ring_link[s]           = ring_link[ring_cursor];
            ring_link[ring_cursor] = SLOT_W'(s);
          end
          ring_cursor = SLOT_W'(s);
          ring_count++;
        end
      end
      rrcl_pkg::CMD_NEXT: begin
        if (ring_count == 0) begin
          r.status = rrcl_pkg::STAT_MISS;
        end else begin
          ring_cursor = ring_link[ring_cursor];
          r.out_value = ring_val[ring_cursor];
        end
      end
      rrcl_pkg::CMD_DEL: begin
        if (ring_count == 0) begin
          r.status = rrcl_pkg::STAT_MISS;
        end else if (ring_count == 1) begin
          if (ring_val[ring_cursor] != val) begin
            r.status = rrcl_pkg::STAT_MISS;
          end else begin
            slot_busy[ring_cursor] = 1'b0;
            ring_count = 0;
          end
        end else begin
          // walk once around, starting after the cursor
          prev = ring_cursor;
          cur  = ring_link[prev];
          done = 1'b0;
          for (i = 0; i < ring_count && !done; i++) begin
            if (ring_val[cur] == val) begin
              ring_link[prev] = ring_link[cur];
              if (ring_cursor == cur) ring_cursor = prev;
              slot_busy[cur] = 1'b0;
              ring_count--;
              done = 1'b1;
            end else begin
              prev = cur;
              cur  = ring_link[cur];
            end
          end
          if (!done) r.status = rrcl_pkg::STAT_MISS;
        end
      end
      default: ;
    endcase
    r.entry_count = rrcl_pkg::ENTRY_W'(ring_count);
    r.is_empty    = (ring_count == 0);
    return r;
  endfunction

  // Gap after a word: mostly none or short, a few long; every third block of 64 runs flat out.
  function automatic int pick_gap();
    int r;
    if ((words_in / 64) % 3 == 1) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic push_word(logic [rrcl_pkg::CMD_W-1:0] cmd,
                           logic [rrcl_pkg::IN_VAL_W-1:0] val);
    cmd_word_t w;
    w.cmd   = cmd;
    w.value = val;
    cmd_words.push_back(w);
  endtask

  // Wait until every queued word went in and every result came back; sampled
  // at the falling edge so the clocked processes have settled.
  task automatic wait_drained();
    while (cmd_words.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
      @(negedge clk_i);
  endtask

  task automatic refresh_pool();
    int i;
    int r;
    for (i = 0; i < POOL_N; i++) begin
      r = $urandom_range(0, 15);
      if (r == 0) val_pool[i] = '0;
      else if (r == 1) val_pool[i] = '1;
      else if (r < 9) val_pool[i] = $urandom;
    end
  endtask

  // One run of random words shaped by mode; values mostly from the pool so deletes hit.
  task automatic add_random_chunk(int mode, int len);
    int k;
    int r;
    logic [rrcl_pkg::CMD_W-1:0] cmd;
    logic [rrcl_pkg::IN_VAL_W-1:0] val;
    for (k = 0; k < len; k++) begin
      r = $urandom_range(0, 99);
      case (mode)
        MODE_ADD_ONLY: cmd = rrcl_pkg::CMD_ADD;
        MODE_FILL:     cmd = (r < 75) ? rrcl_pkg::CMD_ADD : (r < 88) ? rrcl_pkg::CMD_NEXT :
                             (r < 97) ? rrcl_pkg::CMD_DEL : CMD_NONE;
        MODE_DRAIN:    cmd = (r < 15) ? rrcl_pkg::CMD_ADD : (r < 35) ? rrcl_pkg::CMD_NEXT :
                             (r < 97) ? rrcl_pkg::CMD_DEL : CMD_NONE;
        default:       cmd = (r < 35) ? rrcl_pkg::CMD_ADD : (r < 65) ? rrcl_pkg::CMD_NEXT :
                             (r < 95) ? rrcl_pkg::CMD_DEL : CMD_NONE;
      endcase
      if ((cmd == rrcl_pkg::CMD_ADD || cmd == rrcl_pkg::CMD_DEL) &&
          $urandom_range(0, 99) < 83)
        val = val_pool[$urandom_range(0, POOL_N - 1)];
      else
        val = $urandom;
      push_word(cmd, val);
    end
  endtask

  // clock and reset
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Input driver: one valid assignment per edge, next word offered back to back when no gap.
  always @(posedge clk_i or negedge rst_ni) begin : drive_p
    cmd_word_t w;
    bit take;
    int g;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= '0;
      in_gap        <= 0;
    end else begin
      take = 1'b0;
      if (s_axis_tvalid && s_axis_tready) begin
        expected_results.push_back(predict_result(s_axis_tuser, s_axis_tdata));
        words_in <= words_in + 1;
        g = pick_gap();
        if (g == 0 && cmd_words.size() != 0) take = 1'b1;
        else in_gap <= g;
      end else if (!s_axis_tvalid) begin
        if (in_gap > 0) in_gap <= in_gap - 1;
        else if (cmd_words.size() != 0) take = 1'b1;
      end
      if (take) begin
        w = cmd_words.pop_front();
        s_axis_tdata  <= w.value;
        s_axis_tuser  <= w.cmd;
        s_axis_tvalid <= 1'b1;
      end else if (s_axis_tvalid && s_axis_tready) begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver ready: random gaps after each word, one long hold once traffic is going.
  always @(posedge clk_i or negedge rst_ni) begin : ready_p
    int g;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      rdy_gap       <= 0;
      hold_left     <= 0;
    end else if (hold_left > 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (!hold_done && words_in >= 200) begin
      hold_done     <= 1'b1;
      hold_left     <= 600;
      m_axis_tready <= 1'b0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      g = pick_gap();
      rdy_gap       <= g;
      m_axis_tready <= (g == 0);
    end else if (rdy_gap > 0) begin
      rdy_gap       <= rdy_gap - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Result monitor: compare each word against the oldest expectation.
  always @(posedge clk_i) begin : monitor_p
    list_result_t got;
    list_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      words_out <= words_out + 1;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result word, expected none, got %h", $time, got);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (got.out_value !== want.out_value) begin
          $display("%0t: out_value mismatch, expected %h, got %h",
                   $time, want.out_value, got.out_value);
          error_count++;
        end
        if (got.status !== want.status) begin
          $display("%0t: status mismatch, expected %0d, got %0d",
                   $time, want.status, got.status);
          error_count++;
        end
        if (got.entry_count !== want.entry_count) begin
          $display("%0t: entry_count mismatch, expected %0d, got %0d",
                   $time, want.entry_count, got.entry_count);
          error_count++;
        end
        if (got.is_empty !== want.is_empty) begin
          $display("%0t: is_empty mismatch, expected %0d, got %0d",
                   $time, want.is_empty, got.is_empty);
          error_count++;
        end
      end
    end
  end

  // count cycles in which no word moves on either side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : watchdog_p
    while (idle_cycles < IDLE_LIMIT) @(posedge clk_i);
    $display("%0t: watchdog, no word moved for %0d cycles", $time, IDLE_LIMIT);
    $display("status: fail");
    $finish;
  end

  // Stimulus sequence
  initial begin : stim_p
    int made;
    int len;
    int r;
    int mode;
    bit paused;
    made   = 0;
    paused = 1'b0;
    for (int i = 0; i < POOL_N; i++) val_pool[i] = $urandom;

    // directed: empty list, ignored code, single entry, wrap-around, cursor delete, misses
    push_word(rrcl_pkg::CMD_NEXT, 32'h0000_0000);
    push_word(rrcl_pkg::CMD_DEL,  32'h0000_0000);
    push_word(CMD_NONE,           32'hFFFF_FFFF);
    push_word(rrcl_pkg::CMD_ADD,  32'h0000_0000);
    push_word(rrcl_pkg::CMD_DEL,  32'h0000_0001);
    push_word(rrcl_pkg::CMD_NEXT, 32'hFFFF_FFFF);
    push_word(rrcl_pkg::CMD_DEL,  32'h0000_0000);
    push_word(rrcl_pkg::CMD_ADD,  32'hFFFF_FFFF);
    push_word(rrcl_pkg::CMD_ADD,  32'h0000_0000);
    push_word(rrcl_pkg::CMD_ADD,  32'hA5A5_A5A5);
    push_word(rrcl_pkg::CMD_NEXT, 32'h0000_0000);
    push_word(rrcl_pkg::CMD_NEXT, 32'h0000_0000);
    push_word(rrcl_pkg::CMD_NEXT, 32'h0000_0000);
    push_word(rrcl_pkg::CMD_NEXT, 32'h0000_0000);
    push_word(rrcl_pkg::CMD_DEL,  32'h0000_0000);   // hits the cursor entry
    push_word(rrcl_pkg::CMD_NEXT, 32'h0000_0000);
    push_word(rrcl_pkg::CMD_DEL,  32'h1234_5678);
    push_word(CMD_NONE,           32'h0000_0000);
    push_word(rrcl_pkg::CMD_ADD,  32'h8000_0001);
    push_word(rrcl_pkg::CMD_DEL,  32'hA5A5_A5A5);
    push_word(rrcl_pkg::CMD_DEL,  32'hFFFF_FFFF);
    push_word(rrcl_pkg::CMD_DEL,  32'h8000_0001);
    push_word(rrcl_pkg::CMD_NEXT, 32'h0000_0000);
    wait_drained();

    // random part, first chunk overfills the list
    add_random_chunk(MODE_ADD_ONLY, 18);
    made = 18;
    while (made < RAND_WORDS) begin
      if (!paused && made >= RAND_WORDS / 2) begin
        wait_drained();
        paused = 1'b1;
      end
      refresh_pool();
      r    = $urandom_range(0, 99);
      mode = (r < 35) ? MODE_FILL : (r < 70) ? MODE_DRAIN : MODE_MIX;
      len  = $urandom_range(20, 60);
      add_random_chunk(mode, len);
      made += len;
    end

    wait_drained();
    repeat (40) @(posedge clk_i);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
